// ===== hw/rtl/stid_pkg.sv =====
// shared constants and types for the sorted table insert/delete block
`default_nettype none

package stid_pkg;

  localparam int CAPACITY    = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/stid_ram.sv =====
// simple dual-port synchronous ram, one write port and one registered read port
`default_nettype none

module stid_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_table_insert_delete.sv =====
// top level: ascending table of signed values with in-order insert and delete
//
// usage
//   command channel: operation and value are taken at a rising edge where
//   start is high and busy is low; busy stays high while the command runs
//   result channel: done is high for exactly one cycle with status, count and
//   position valid; the receiver cannot stall it, so no result is ever held
//
// operation
//   the table lives in one ram (one write port, one registered read port); a
//   command sweeps entries 0..count-1 in ascending order, one read
//   issued per cycle, and rewrites entries behind the read pointer
//   insert: finds the first entry not smaller than the value, writes the value
//   there and ripples the displaced entries up by one through a carry register
//   delete: finds the first equal entry and moves every later entry down by one
//
// command flow
//   the done strobe rises once the sweep has covered every entry held before
//   the command; an insert into a full table or a command on an empty table
//   skips the sweep; a new command can be taken in the cycle the strobe
//   shows, and only one command runs at a time; the sweep length is set by
//   the single ram read port
//
// reset
//   rst (synchronous) empties the table and returns to idle; ram contents are
//   left as they are, since only entries below count are ever read
`default_nettype none

module sorted_table_insert_delete
  import stid_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          operation,
  input  wire logic signed [VALUE_WIDTH-1:0] value,
  output logic                               done,
  output logic             [1:0]             status,
  output logic             [CNT_W-1:0]       count,
  output logic             [IDX_W-1:0]       position
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t state, state_next;

  // control state
  logic [CNT_W-1:0] entry_count, entry_count_next;
  logic [CNT_W-1:0] idx, idx_next;        // next entry to read
  logic             pend, pend_next;      // read data arrives this cycle
  logic             found, found_next;    // target slot located
  logic             done_next;

  // command and sweep payload
  logic                          op, op_next;
  logic signed [VALUE_WIDTH-1:0] val, val_next;
  logic signed [VALUE_WIDTH-1:0] carry, carry_next;   // entry displaced by insert
  logic [IDX_W-1:0]              pidx, pidx_next;     // index of pending read data
  logic [IDX_W-1:0]              pos, pos_next;       // slot inserted or removed

  // result registers
  status_t          res_status, res_status_next;
  logic [CNT_W-1:0] res_count, res_count_next;
  logic [IDX_W-1:0] res_pos, res_pos_next;

  // ram port signals
  logic                          ram_we;
  logic [IDX_W-1:0]              ram_waddr;
  logic signed [VALUE_WIDTH-1:0] ram_wdata;
  logic                          ram_re;
  logic [IDX_W-1:0]              ram_raddr;
  logic signed [VALUE_WIDTH-1:0] ram_rdata;

  stid_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (VALUE_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next       = state;
    entry_count_next = entry_count;
    idx_next         = idx;
    pend_next        = 1'b0;
    found_next       = found;
    done_next        = 1'b0;
    op_next          = op;
    val_next         = val;
    carry_next       = carry;
    pidx_next        = pidx;
    pos_next         = pos;
    res_status_next  = res_status;
    res_count_next   = res_count;
    res_pos_next     = res_pos;
    ram_we           = 1'b0;
    ram_waddr        = pidx;
    ram_wdata        = carry;
    ram_re           = 1'b0;
    ram_raddr        = idx[IDX_W-1:0];

    unique case (state)
      S_IDLE: begin
        if (start) begin
          op_next    = operation;
          val_next   = value;
          idx_next   = '0;
          found_next = 1'b0;
          pos_next   = '0;
          state_next = S_RUN;
        end
      end

      S_RUN: begin
        priority if (op == OP_INSERT && entry_count == CNT_W'(CAPACITY)) begin
          // table full, insert refused
          res_status_next = ST_FULL;
          res_count_next  = entry_count;
          res_pos_next    = '0;
          done_next       = 1'b1;
          state_next      = S_IDLE;
        end else if (idx == entry_count && !pend) begin
          // sweep drained: close out the command
          if (op == OP_INSERT) begin
            ram_we           = 1'b1;
            ram_waddr        = entry_count[IDX_W-1:0];
            ram_wdata        = found ? carry : val;
            entry_count_next = entry_count + 1'b1;
            res_status_next  = ST_DONE;
            res_count_next   = entry_count + 1'b1;
            res_pos_next     = found ? pos : entry_count[IDX_W-1:0];
          end else if (found) begin
            entry_count_next = entry_count - 1'b1;
            res_status_next  = ST_DONE;
            res_count_next   = entry_count - 1'b1;
            res_pos_next     = pos;
          end else begin
            res_status_next  = ST_NOT_FOUND;
            res_count_next   = entry_count;
            res_pos_next     = '0;
          end
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          // handle data read last cycle
          if (pend) begin
            if (op == OP_INSERT) begin
              if (!found) begin
                if (!(val > ram_rdata)) begin
                  found_next = 1'b1;
                  pos_next   = pidx;
                  ram_we     = 1'b1;
                  ram_waddr  = pidx;
                  ram_wdata  = val;
                  carry_next = ram_rdata;
                end
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = pidx;
                ram_wdata  = carry;
                carry_next = ram_rdata;
              end
            end else begin
              if (!found) begin
                if (ram_rdata == val) begin
                  found_next = 1'b1;
                  pos_next   = pidx;
                end
              end else begin
                // shift down into the slot behind
                ram_we    = 1'b1;
                ram_waddr = pidx - 1'b1;
                ram_wdata = ram_rdata;
              end
            end
          end
          // issue next read; writes always trail the read address
          if (idx < entry_count) begin
            ram_re    = 1'b1;
            ram_raddr = idx[IDX_W-1:0];
            pidx_next = idx[IDX_W-1:0];
            idx_next  = idx + 1'b1;
            pend_next = 1'b1;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      idx         <= '0;
      pend        <= 1'b0;
      found       <= 1'b0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      idx         <= idx_next;
      pend        <= pend_next;
      found       <= found_next;
      done        <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    op         <= op_next;
    val        <= val_next;
    carry      <= carry_next;
    pidx       <= pidx_next;
    pos        <= pos_next;
    res_status <= res_status_next;
    res_count  <= res_count_next;
    res_pos    <= res_pos_next;
  end

  assign busy     = (state != S_IDLE);
  assign status   = res_status;
  assign count    = res_count;
  assign position = res_pos;

endmodule

`default_nettype wire

// ===== hw/rtl/stid_checker.sv =====
// port-level checker for the sorted table block, bound to the top level
`default_nettype none

module stid_checker
  import stid_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             start,
  input wire logic             busy,
  input wire logic             done,
  input wire logic [1:0]       status,
  input wire logic [CNT_W-1:0] count,
  input wire logic [IDX_W-1:0] position
);

  // an accepted transfer keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  // a result only follows a cycle of work
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a running command");

  // two result strobes never come back to back
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("back-to-back result strobes");

  // a refused insert only happens on a full table
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_FULL |-> count == CNT_W'(CAPACITY))
    else $error("full status with table not full");

  // failed commands report position zero
  a_fail_pos: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_DONE |-> position == '0)
    else $error("failed command with nonzero position");

endmodule

bind sorted_table_insert_delete stid_checker u_stid_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .status   (status),
  .count    (count),
  .position (position)
);

`default_nettype wire

// ===== test/tb_top.sv =====
// testbench for sorted_table_insert_delete: self-checking insert/delete traffic against a table mirror
`timescale 1ns / 100ps

module tb_top;
  import stid_pkg::*;

  // run shape
  localparam int ITEMS_PER_PHASE = 400;
  localparam int N_PHASES        = 4;
  // slowest item is a full-table sweep plus sender gaps, ~1.6k items
  localparam int CYCLE_LIMIT     = 1_000_000;
  // longest sweep plus margin, used once all results are in
  localparam int TAIL_CYCLES     = CAPACITY + 8;
  localparam int POOL_SIZE       = 6;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  typedef struct packed {
    logic   op;
    value_t val;
  } table_cmd_t;

  typedef struct packed {
    status_t          status;
    logic [CNT_W-1:0] count;
    logic [IDX_W-1:0] position;
  } table_result_t;

  localparam value_t V_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam value_t V_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

  // dut ports, every input known from time zero
  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             start     = 1'b0;
  logic             operation = OP_INSERT;
  value_t           value     = '0;
  logic             busy;
  logic             done;
  logic [1:0]       status;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] position;

  // commands waiting to be driven, filled by the stimulus process
  table_cmd_t    cmd_backlog[$];
  // expected results in transfer order, filled at acceptance
  table_result_t pending_results[$];

  // what the stimulus process believes the table holds (unordered), so it can
  // aim deletes at stored values and steer the fill level
  value_t        gen_contents[$];
  value_t        gen_pool[POOL_SIZE];

  // mirror of the table, advanced once per accepted command
  value_t        mirror_vals[CAPACITY];
  int unsigned   mirror_len = 0;

  int unsigned   n_queued    = 0;
  int unsigned   n_accepted  = 0;
  int unsigned   gap_pct     = 0;
  int unsigned   cycle_count = 0;
  bit            failed      = 1'b0;

  table_cmd_t    next_cmd;
  table_result_t want;

  sorted_table_insert_delete dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .operation (operation),
    .value     (value),
    .done      (done),
    .status    (status),
    .count     (count),
    .position  (position)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // mirror update: returns the result one command must produce
  // ---------------------------------------------------------------------------
  function automatic table_result_t apply_to_mirror(logic op, value_t val);
    table_result_t r;
    int unsigned   p;
    r.status   = ST_DONE;
    r.position = '0;
    p          = 0;
    if (op == OP_INSERT) begin
      if (mirror_len >= CAPACITY) begin
        // full table refuses, nothing moves
        r.status = ST_FULL;
      end else begin
        // land ahead of the first entry that is not smaller, so a new value
        // goes in front of equal ones already stored
        while (p < mirror_len && val > mirror_vals[p]) p++;
        for (int unsigned i = mirror_len; i > p; i--) mirror_vals[i] = mirror_vals[i-1];
        mirror_vals[p] = val;
        mirror_len++;
        r.position = IDX_W'(p);
      end
    end else begin
      // lowest-index equal entry goes, later entries close the gap
      while (p < mirror_len && mirror_vals[p] != val) p++;
      if (p < mirror_len) begin
        for (int unsigned i = p; i + 1 < mirror_len; i++) mirror_vals[i] = mirror_vals[i+1];
        mirror_len--;
        r.position = IDX_W'(p);
      end else begin
        // covers the empty table too
        r.status = ST_NOT_FOUND;
      end
    end
    r.count = CNT_W'(mirror_len);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_cmd(logic op, value_t val);
    table_cmd_t  c;
    int          hit;
    c.op  = op;
    c.val = val;
    cmd_backlog.push_back(c);
    n_queued++;
    // keep the generator's view of the contents in step
    if (op == OP_INSERT) begin
      if (gen_contents.size() < CAPACITY) gen_contents.push_back(val);
    end else begin
      hit = -1;
      for (int i = 0; i < gen_contents.size() && hit < 0; i++)
        if (gen_contents[i] == val) hit = i;
      if (hit >= 0) gen_contents.delete(hit);
    end
  endtask

  // extremes now and then, a small pool for duplicates, otherwise any 32 bits
  function automatic value_t pick_value();
    int unsigned r;
    value_t      v;
    r = $urandom_range(99);
    if (r < 10) begin
      case ($urandom_range(3))
        0:       v = V_MIN;
        1:       v = V_MAX;
        2:       v = '0;
        default: v = '1;
      endcase
    end else if (r < 45) begin
      v = gen_pool[$urandom_range(POOL_SIZE-1)];
    end else begin
      v = value_t'($urandom());
    end
    return v;
  endfunction

  // alternating fill and drain episodes; most run all the way to a full or an
  // empty table and then push a few more commands against that edge
  task automatic queue_episodes(int unsigned n_items);
    bit          filling;
    int unsigned target;
    int unsigned extra;
    int unsigned ins_pct;
    filling = gen_contents.size() >= CAPACITY / 2;
    while (n_items > 0) begin
      filling = !filling;
      for (int k = 0; k < POOL_SIZE; k++)
        gen_pool[k] = $urandom_range(1) ? value_t'($urandom())
                                        : value_t'($urandom_range(20)) - value_t'(10);
      if (filling)
        target = ($urandom_range(2) != 0) ? CAPACITY : $urandom_range(CAPACITY-1, CAPACITY/2);
      else
        target = ($urandom_range(2) != 0) ? 0 : $urandom_range(CAPACITY/2, 1);
      ins_pct = filling ? 85 : 15;
      extra   = $urandom_range(4, 1);
      while (n_items > 0 && extra > 0) begin
        if (filling ? gen_contents.size() >= target : gen_contents.size() <= target) extra--;
        if ($urandom_range(99) < ins_pct)
          queue_cmd(OP_INSERT, pick_value());
        else if (gen_contents.size() != 0 && $urandom_range(99) < 75)
          queue_cmd(OP_DELETE, gen_contents[$urandom_range(gen_contents.size()-1)]);
        else
          queue_cmd(OP_DELETE, pick_value());
        n_items--;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: busy is sampled as it stood before the edge, so start && !busy
  // here is exactly the transfer the dut took at this edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        pending_results.push_back(apply_to_mirror(operation, value));
        n_accepted++;
      end
      // slot is free when nothing is offered or the offer was just taken;
      // start gets a single assignment per edge
      if (!start || !busy) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= gap_pct) begin
          next_cmd  = cmd_backlog.pop_front();
          start     <= 1'b1;
          operation <= next_cmd.op;
          value     <= next_cmd.val;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: one result per done cycle, the receiver never holds it off
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && done !== 1'b0) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: done %b status %0d count %0d position %0d",
               done, status, count, position);
        failed = 1'b1;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status);
          failed = 1'b1;
        end
        if (count !== want.count) begin
          $error("count: expected %0d, actual %0d", want.count, count);
          failed = 1'b1;
        end
        if (position !== want.position) begin
          $error("position: expected %0d, actual %0d", want.position, position);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence: reset, directed cases, then random phases with different gaps
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // queue and gap updates happen away from the active edge
    @(negedge clk);

    // delete on an empty table
    queue_cmd(OP_DELETE, value_t'(5));
    // extremes and ordering around zero
    queue_cmd(OP_INSERT, '0);
    queue_cmd(OP_INSERT, V_MAX);
    queue_cmd(OP_INSERT, V_MIN);
    queue_cmd(OP_INSERT, '1);
    // equal value lands in front of the stored one
    queue_cmd(OP_INSERT, '0);
    queue_cmd(OP_INSERT, value_t'(1));
    queue_cmd(OP_INSERT, V_MIN);
    // duplicates removed lowest index first
    queue_cmd(OP_DELETE, '0);
    queue_cmd(OP_DELETE, V_MIN);
    // absent value with a populated table
    queue_cmd(OP_DELETE, value_t'(12345));
    queue_cmd(OP_DELETE, V_MAX);
    queue_cmd(OP_DELETE, V_MIN);
    queue_cmd(OP_DELETE, '1);
    queue_cmd(OP_DELETE, '0);
    queue_cmd(OP_DELETE, value_t'(1));
    // table is empty again
    queue_cmd(OP_DELETE, '0);
    queue_cmd(OP_INSERT, V_MAX);
    queue_cmd(OP_DELETE, V_MIN);
    queue_cmd(OP_DELETE, V_MAX);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      // phase plan: back to back, sparse sender, light gaps, back to back
      gap_pct = (ph == 1) ? 53 : (ph == 2) ? 6 : 0;
      queue_episodes(ITEMS_PER_PHASE);
      while (n_accepted != n_queued || pending_results.size() != 0) @(negedge clk);
    end

    // let a stray strobe show up before the verdict
    repeat (TAIL_CYCLES) @(negedge clk);
    if (!failed)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
